>>> rtl/crds_pkg.sv
// Package for the rotating cube depth sorter: widths, face table, codes, command struct.
// No dependencies; imported by every module under rtl/.
package crds_pkg;
    localparam int CoordW    = 32;
    localparam int TrigW     = 18;
    localparam int ScrW      = 10;
    localparam int DepthW    = 35;
    localparam int FracBitsDefault = 16;
    localparam int RotShift  = 16;

    localparam logic [1:0] RegCos = 2'd0;
    localparam logic [1:0] RegSin = 2'd1;
    localparam logic [1:0] RegCx  = 2'd2;
    localparam logic [1:0] RegCy  = 2'd3;

    // rotation micro-steps for one vertex
    typedef enum logic [2:0] {
        ROT_Y1 = 3'd0, ROT_ZT = 3'd1, ROT_Z = 3'd2,
        ROT_XT = 3'd3, ROT_X  = 3'd4, ROT_Y2 = 3'd5
    } t_rot_op;

    typedef struct packed {
        logic       load_vtx;
        logic       rot_en;
        t_rot_op    rot_op;
        logic [2:0] vtx;
        logic       rot_wr;
        logic       depth_en;
        logic [2:0] face;
        logic       sort_clr;
        logic       sort_scan;
        logic [2:0] sort_i;
        logic [2:0] sort_j;
        logic       sort_swap;
        logic       emit;
        logic [1:0] emit_k;
    } t_cmd;

    function automatic logic [2:0] face_vtx(input logic [2:0] f, input logic [1:0] k);
        logic [11:0] row;
        begin
            unique case (f)
                3'd0: row = {3'd2, 3'd3, 3'd1, 3'd0};
                3'd1: row = {3'd6, 3'd2, 3'd0, 3'd4};
                3'd2: row = {3'd7, 3'd6, 3'd4, 3'd5};
                3'd3: row = {3'd3, 3'd7, 3'd5, 3'd1};
                3'd4: row = {3'd4, 3'd5, 3'd1, 3'd0};
                3'd5: row = {3'd6, 3'd7, 3'd3, 3'd2};
                default: row = '0;
            endcase
            face_vtx = row[k*3 +: 3];
        end
    endfunction
endpackage

>>> rtl/crds_ctrl.sv
// Sequencer for the cube block: steps rotation, depth sums, selection sort and emission.
// Depends on crds_pkg.
module crds_ctrl
    import crds_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    output t_cmd o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_LOAD = 7'b0000010, S_ROT = 7'b0000100,
        S_WB   = 7'b0001000, S_DEP  = 7'b0010000, S_SORT = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_a, n_a;       // vertex / face / sort i
    logic [2:0] r_b, n_b;       // rot op / sort j
    logic [1:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_a <= '0; r_b <= '0; r_k <= '0;
        end else begin
            r_state <= n_state;
            r_a <= n_a; r_b <= n_b; r_k <= n_k;
        end
    end

    always_comb begin
        n_state = r_state; n_a = r_a; n_b = r_b; n_k = r_k;
        o_cmd = '0;
        o_cmd.vtx = r_a;
        o_cmd.face = r_a;
        o_cmd.sort_i = r_a;
        o_cmd.sort_j = r_b;
        o_cmd.rot_op = t_rot_op'(r_b);
        o_cmd.emit_k = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_LOAD; n_a = '0;
                end
            end
            S_LOAD: begin
                o_cmd.load_vtx = 1'b1;
                n_b = 3'd0; n_state = S_ROT;
            end
            S_ROT: begin
                // multiply cycle; result written next cycle
                o_cmd.rot_en = 1'b1;
                n_state = S_WB;
            end
            S_WB: begin
                o_cmd.rot_wr = 1'b1;
                if (r_b == 3'd5) begin
                    if (r_a == 3'd7) begin
                        n_a = '0; n_state = S_DEP;
                    end else begin
                        n_a = r_a + 3'd1; n_state = S_LOAD;
                    end
                end else begin
                    n_b = r_b + 3'd1; n_state = S_ROT;
                end
            end
            S_DEP: begin
                o_cmd.depth_en = 1'b1;
                if (r_a == 3'd5) begin
                    n_a = '0; n_b = 3'd1; n_state = S_SORT;
                end else begin
                    n_a = r_a + 3'd1;
                end
            end
            S_SORT: begin
                o_cmd.sort_clr = (r_b == r_a + 3'd1);
                o_cmd.sort_scan = (r_b != 3'd6);
                o_cmd.sort_swap = (r_b == 3'd6);
                if (r_b == 3'd6) begin
                    if (r_a == 3'd4) begin
                        n_k = '0; n_state = S_EMIT;
                    end else begin
                        n_a = r_a + 3'd1; n_b = r_a + 3'd2;
                    end
                end else begin
                    n_b = r_b + 3'd1;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (r_k == 2'd2) n_state = S_IDLE;
                else n_k = r_k + 2'd1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    a_emit_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_k == 2'd2) |=> r_state == S_IDLE)
        else $error("emission did not end after third face");
    a_wb_after_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT) |=> r_state == S_WB)
        else $error("rotation write-back skipped");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> r_state == S_LOAD)
        else $error("start not taken");
endmodule

>>> rtl/crds_datapath.sv
// Datapath: vertex store, shared rotate unit, depth sums, sorter and output registers.
// Depends on crds_pkg.
module crds_datapath
    import crds_pkg::*;
#(
    parameter int FRAC_BITS = FracBitsDefault
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic signed [TrigW-1:0]  i_cos,
    input  logic signed [TrigW-1:0]  i_sin,
    input  logic [8:0]               i_cx,
    input  logic [7:0]               i_cy,
    output logic                     o_valid,
    output logic [2:0]               o_face_id,
    output logic [2:0]               o_face_color,
    output logic signed [ScrW-1:0]   o_cx [4],
    output logic signed [ScrW-1:0]   o_cy [4],
    output logic                     o_last
);
    localparam logic signed [CoordW-1:0] Half = CoordW'(50) <<< FRAC_BITS;

    // vertex store: x,y,z per corner in flops (fixed-place reads per face)
    logic signed [CoordW-1:0] r_vx [8];
    logic signed [CoordW-1:0] r_vy [8];
    logic signed [CoordW-1:0] r_vz [8];
    // working copy of the vertex being rotated
    logic signed [CoordW-1:0] r_px, r_py, r_pz, r_y0, r_zt, r_xt;
    logic signed [CoordW+TrigW-1:0] r_pa, r_pb;
    logic r_minus;
    logic signed [CoordW-1:0] rot_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_vx[i] <= i[2] ? Half : -Half;
                r_vy[i] <= i[1] ? Half : -Half;
                r_vz[i] <= i[0] ? Half : -Half;
            end
        end else if (i_cmd.rot_wr && i_cmd.rot_op == ROT_Y2) begin
            r_vx[i_cmd.vtx] <= r_px;
            r_vy[i_cmd.vtx] <= rot_res;
            r_vz[i_cmd.vtx] <= r_pz;
        end
    end

    // operand select for a*c +/- b*s
    logic signed [CoordW-1:0] op_a, op_b;
    logic op_minus;
    always_comb begin
        unique case (i_cmd.rot_op)
            ROT_Y1:  begin op_a = r_py; op_b = r_pz; op_minus = 1'b1; end
            ROT_ZT:  begin op_a = r_pz; op_b = r_y0; op_minus = 1'b0; end
            ROT_Z:   begin op_a = r_zt; op_b = r_px; op_minus = 1'b0; end
            ROT_XT:  begin op_a = r_px; op_b = r_zt; op_minus = 1'b1; end
            ROT_X:   begin op_a = r_xt; op_b = r_py; op_minus = 1'b1; end
            ROT_Y2:  begin op_a = r_py; op_b = r_xt; op_minus = 1'b0; end
            default: begin op_a = r_py; op_b = r_pz; op_minus = 1'b1; end
        endcase
    end

    // product sum, floor shift, saturate
    logic signed [CoordW+TrigW:0] sum_t;
    logic signed [CoordW+TrigW-RotShift:0] sum_q;
    assign sum_t = r_minus ? (CoordW+TrigW+1)'(r_pa) - (CoordW+TrigW+1)'(r_pb)
                           : (CoordW+TrigW+1)'(r_pa) + (CoordW+TrigW+1)'(r_pb);
    assign sum_q = sum_t[CoordW+TrigW:RotShift];
    always_comb begin
        if (sum_q > (CoordW+TrigW-RotShift+1)'($signed(32'h7FFFFFFF)))
            rot_res = 32'sh7FFFFFFF;
        else if (sum_q < (CoordW+TrigW-RotShift+1)'($signed(32'h80000000)))
            rot_res = 32'sh80000000;
        else
            rot_res = sum_q[CoordW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vtx) begin
            r_px <= r_vx[i_cmd.vtx];
            r_py <= r_vy[i_cmd.vtx];
            r_pz <= r_vz[i_cmd.vtx];
            r_y0 <= r_vy[i_cmd.vtx];
        end
        if (i_cmd.rot_en) begin
            r_pa    <= op_a * i_cos;
            r_pb    <= op_b * i_sin;
            r_minus <= op_minus;
        end
        if (i_cmd.rot_wr) begin
            unique case (i_cmd.rot_op)
                ROT_Y1:  r_py <= rot_res;
                ROT_ZT:  r_zt <= rot_res;
                ROT_Z:   r_pz <= rot_res;
                ROT_XT:  r_xt <= rot_res;
                ROT_X:   r_px <= rot_res;
                ROT_Y2:  r_py <= rot_res;
                default: r_py <= rot_res;
            endcase
        end
    end

    // depth sums and sort order
    logic signed [DepthW-1:0] r_depth [6];
    logic [2:0] r_order [6];
    logic [2:0] r_min;
    logic signed [DepthW-1:0] dsum;
    assign dsum = DepthW'(r_vz[face_vtx(i_cmd.face, 2'd0)]) + DepthW'(r_vz[face_vtx(i_cmd.face, 2'd1)])
                + DepthW'(r_vz[face_vtx(i_cmd.face, 2'd2)]) + DepthW'(r_vz[face_vtx(i_cmd.face, 2'd3)]);

    logic [2:0] cur_min;
    assign cur_min = i_cmd.sort_clr ? i_cmd.sort_i : r_min;

    always_ff @(posedge i_clk) begin
        if (i_cmd.depth_en) begin
            r_depth[i_cmd.face] <= dsum;
            r_order[i_cmd.face] <= i_cmd.face;
        end
        if (i_cmd.sort_scan) begin
            r_min <= (r_depth[i_cmd.sort_j] < r_depth[cur_min]) ? i_cmd.sort_j : cur_min;
        end
        // minimum already in place: nothing to swap
        if (i_cmd.sort_swap && r_min != i_cmd.sort_i) begin
            r_depth[r_min] <= r_depth[i_cmd.sort_i];
            r_depth[i_cmd.sort_i] <= r_depth[r_min];
            r_order[r_min] <= r_order[i_cmd.sort_i];
            r_order[i_cmd.sort_i] <= r_order[r_min];
        end
    end

    // projection: truncate toward zero, add centre, saturate
    function automatic logic signed [ScrW-1:0] scr(input logic signed [CoordW-1:0] c,
                                                   input logic [8:0] ctr);
        logic signed [CoordW-1:0] p;
        logic signed [CoordW:0] s;
        begin
            p = c >>> FRAC_BITS;
            if (c < 0 && (c & ((CoordW'(1) <<< FRAC_BITS) - 1)) != 0) p = p + 1;
            s = (CoordW+1)'(p) + (CoordW+1)'({1'b0, ctr});
            if (s > 511) scr = 10'sd511;
            else if (s < -512) scr = -10'sd512;
            else scr = s[ScrW-1:0];
        end
    endfunction

    logic [2:0] ef;
    assign ef = r_order[3'd3 + {1'b0, i_cmd.emit_k}];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else o_valid <= i_cmd.emit;
        if (i_cmd.emit) begin
            o_face_id    <= ef;
            o_face_color <= ef + 3'd2;
            o_last       <= (i_cmd.emit_k == 2'd2);
            for (int k = 0; k < 4; k++) begin
                o_cx[k] <= scr(r_vx[face_vtx(ef, 2'(k))], i_cx);
                o_cy[k] <= scr(r_vy[face_vtx(ef, 2'(k))], {1'b0, i_cy});
            end
        end
    end

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("beat after last face");
    a_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_face_color == o_face_id + 3'd2)
        else $error("colour mismatch");
    a_swap_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sort_swap |-> r_min >= i_cmd.sort_i)
        else $error("sort minimum before base");
endmodule

>>> rtl/cube_rotate_and_depth_sort.sv
// Top level of the rotating cube depth sorter: config registers, controller, datapath.
// Depends on crds_pkg, crds_ctrl, crds_datapath.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------
//  command  | start / busy            | i_frame_tick
//  config   | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//  result   | o_strobe (one beat)     | face id, colour, 4 corners, last
//
// One frame loads each of the 8 vertices and rotates it in six steps (multiply,
// then write-back) through the single shared multiply unit, then forms the 6
// depth sums, runs the selection sort and emits 3 faces; the last beat is
// registered and shows in the first cycle with busy low. A tick with frame_tick
// low is taken and gives no beat. Reset is synchronous and restores the
// cube corners and the register defaults. The receiver cannot stall; each
// beat stands for one cycle.
module cube_rotate_and_depth_sort
    import crds_pkg::*;
#(
    parameter int FRAC_BITS = FracBitsDefault
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_frame_tick,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [TrigW-1:0]        i_cfg_data,
    output logic                    o_strobe,
    output logic [2:0]              o_face_id,
    output logic [2:0]              o_face_color,
    output logic signed [ScrW-1:0]  o_corner0_x,
    output logic signed [ScrW-1:0]  o_corner0_y,
    output logic signed [ScrW-1:0]  o_corner1_x,
    output logic signed [ScrW-1:0]  o_corner1_y,
    output logic signed [ScrW-1:0]  o_corner2_x,
    output logic signed [ScrW-1:0]  o_corner2_y,
    output logic signed [ScrW-1:0]  o_corner3_x,
    output logic signed [ScrW-1:0]  o_corner3_y,
    output logic                    o_last_face
);
    logic signed [TrigW-1:0] r_cos, r_sin;
    logic [8:0] r_cx;
    logic [7:0] r_cy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos <= TrigW'(65507);
            r_sin <= TrigW'(1966);
            r_cx  <= 9'd160;
            r_cy  <= 8'd128;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegCos: r_cos <= i_cfg_data;
                RegSin: r_sin <= i_cfg_data;
                RegCx:  r_cx  <= i_cfg_data[8:0];
                RegCy:  r_cy  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    t_cmd cmd;
    logic ctl_busy;

    // a zero tick is accepted and dropped
    crds_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start && i_frame_tick),
        .o_busy  (ctl_busy),
        .o_cmd   (cmd)
    );
    assign busy = ctl_busy;

    logic signed [ScrW-1:0] cx [4];
    logic signed [ScrW-1:0] cy [4];

    crds_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cos        (r_cos),
        .i_sin        (r_sin),
        .i_cx         (r_cx),
        .i_cy         (r_cy),
        .o_valid      (o_strobe),
        .o_face_id    (o_face_id),
        .o_face_color (o_face_color),
        .o_cx         (cx),
        .o_cy         (cy),
        .o_last       (o_last_face)
    );

    assign o_corner0_x = cx[0]; assign o_corner0_y = cy[0];
    assign o_corner1_x = cx[1]; assign o_corner1_y = cy[1];
    assign o_corner2_x = cx[2]; assign o_corner2_y = cy[2];
    assign o_corner3_x = cx[3]; assign o_corner3_y = cy[3];

    a_no_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !$past(busy)) |-> !o_strobe)
        else $error("beat while idle");
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_frame_tick) |=> busy)
        else $error("frame not started");
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_face) |-> !busy)
        else $error("busy after last beat");
endmodule
